// ===== rtl/bec_pkg.sv =====
// bounce easing curve: shared widths, codes and fixed constants
package bec_pkg;

  localparam int unsigned STEP_W = 16;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned U_BITS = 18;
  localparam int unsigned U_W    = U_BITS + 1;
  localparam int unsigned DIV_STEPS = U_BITS + 1;
  localparam int unsigned M_W    = 22;
  localparam int unsigned ABS_W  = 21;
  localparam int unsigned SQ_W   = 2 * ABS_W;

  localparam logic [U_W-1:0] U_ONE  = U_W'(1) << U_BITS;
  localparam logic [U_W-1:0] U_HALF = U_W'(1) << (U_BITS - 1);

  // breakpoints and centers, scaled by 11 (last one by 22)
  localparam logic [M_W-1:0] M_BRK1 = M_W'(4)  << U_BITS;
  localparam logic [M_W-1:0] M_BRK2 = M_W'(8)  << U_BITS;
  localparam logic [M_W-1:0] M_BRK3 = M_W'(10) << U_BITS;
  localparam logic [M_W:0]   M_CTR1 = (M_W+1)'(6)  << U_BITS;
  localparam logic [M_W:0]   M_CTR2 = (M_W+1)'(9)  << U_BITS;
  localparam logic [M_W:0]   M_CTR3 = (M_W+1)'(21) << U_BITS;

  typedef logic [1:0] seg_t;
  localparam seg_t SEG_FIRST  = 2'd0;
  localparam seg_t SEG_SECOND = 2'd1;
  localparam seg_t SEG_THIRD  = 2'd2;
  localparam seg_t SEG_LAST   = 2'd3;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_OUT   = 2'd0;
  localparam mode_t MODE_IN    = 2'd1;
  localparam mode_t MODE_INOUT = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MODE     = 2'd0;
  localparam reg_idx_t REG_BEGIN    = 2'd1;
  localparam reg_idx_t REG_CHANGE   = 2'd2;
  localparam reg_idx_t REG_DURATION = 2'd3;

  localparam logic [STEP_W-1:0] DURATION_RST = 16'd100;

endpackage

// ===== rtl/bounce_easing_curve_top.sv =====
// bounce easing curve: pipelined divider, segment square and scaling
//
//  channel   dir  ports                                     word
//  in        in   in_valid, in_ready, in_elapsed_step       one step count
//  out       out  out_valid, out_ready, out_position        one eased position
//  cfg       in   cfg_we, cfg_index, cfg_wdata              one register write
//
// one word enters per cycle while in_ready is high; the path to out_valid has
// 27 register stages: 1 saturate, 19 divider, 6 curve/scale, output register
// rst_n is synchronous; it clears valid bits and loads register defaults
// a stall first parks one finished word in a skid register behind the output
// register; while it is held the whole pipe freezes and in_ready, a flop, is low
module bounce_easing_curve_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_elapsed_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [16:0] out_position,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned CW  = FRAC_BITS + 1;
  localparam int unsigned GW  = FRAC_BITS + 2;
  localparam int unsigned PW  = FRAC_BITS + 19;
  localparam int unsigned SH0 = 2 * bec_pkg::U_BITS + 4 - FRAC_BITS;
  localparam int unsigned SH3 = SH0 + 2;
  localparam int unsigned NDIV = bec_pkg::DIV_STEPS;
  localparam logic [bec_pkg::SQ_W:0] RND0 = (bec_pkg::SQ_W+1)'(1) << (SH0 - 1);
  localparam logic [bec_pkg::SQ_W:0] RND3 = (bec_pkg::SQ_W+1)'(1) << (SH3 - 1);
  localparam logic [CW-1:0] C_ONE = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] OFF1  = CW'(3)  << (FRAC_BITS - 2);
  localparam logic [CW-1:0] OFF2  = CW'(15) << (FRAC_BITS - 4);
  localparam logic [CW-1:0] OFF3  = CW'(63) << (FRAC_BITS - 6);
  localparam logic signed [PW-1:0] P_HALF = PW'(1) << FRAC_BITS;

  // configuration registers
  bec_pkg::mode_t     ease_mode_r;
  logic signed [15:0] begin_value_r;
  logic signed [15:0] change_amount_r;
  logic [15:0]        duration_steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ease_mode_r      <= bec_pkg::MODE_OUT;
      begin_value_r    <= '0;
      change_amount_r  <= '0;
      duration_steps_r <= bec_pkg::DURATION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bec_pkg::REG_MODE:     ease_mode_r      <= cfg_wdata[1:0];
        bec_pkg::REG_BEGIN:    begin_value_r    <= cfg_wdata;
        bec_pkg::REG_CHANGE:   change_amount_r  <= cfg_wdata;
        bec_pkg::REG_DURATION: duration_steps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipe control
  logic en;
  logic skid_valid_r;
  logic out_valid_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  // stage valid bits
  logic              sat_vld_r;
  logic [NDIV-1:0]   div_vld_r;
  logic              map_vld_r, seg_vld_r, sq_vld_r, crv_vld_r, g_vld_r, mul_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_vld_r <= 1'b0;
      div_vld_r <= '0;
      map_vld_r <= 1'b0;
      seg_vld_r <= 1'b0;
      sq_vld_r  <= 1'b0;
      crv_vld_r <= 1'b0;
      g_vld_r   <= 1'b0;
      mul_vld_r <= 1'b0;
    end else if (en) begin
      sat_vld_r <= in_valid;
      div_vld_r <= {div_vld_r[NDIV-2:0], sat_vld_r};
      map_vld_r <= div_vld_r[NDIV-1];
      seg_vld_r <= map_vld_r;
      sq_vld_r  <= seg_vld_r;
      crv_vld_r <= sq_vld_r;
      g_vld_r   <= crv_vld_r;
      mul_vld_r <= g_vld_r;
    end
  end

  // saturate step count to the duration
  logic [15:0] sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= (in_elapsed_step > duration_steps_r) ? duration_steps_r : in_elapsed_step;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  logic [15:0]             rem_r [NDIV];
  logic [bec_pkg::U_W-1:0] quo_r [NDIV];

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [15:0]             rem_in;
    logic [bec_pkg::U_W-1:0] quo_in;
    logic [16:0]             trial;
    logic                    ge;
    logic [16:0]             diff;

    if (j == 0) begin : g_first
      assign rem_in = sat_r;
      assign quo_in = '0;
      assign trial  = {1'b0, rem_in};
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign trial  = {rem_in, 1'b0};
    end

    assign ge   = trial >= {1'b0, duration_steps_r};
    assign diff = trial - {1'b0, duration_steps_r};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[15:0] : trial[15:0];
        quo_r[j] <= {quo_in[bec_pkg::U_W-2:0], ge};
      end
    end
  end

  // map u to the curve argument for the mode
  logic [bec_pkg::U_W-1:0] u_val;
  logic [bec_pkg::U_W:0]   u_dbl;
  logic [bec_pkg::U_W:0]   v_nxt;
  logic                    lo_nxt;
  logic [bec_pkg::U_W-1:0] v_r;
  logic                    lo_r;

  always_comb begin
    u_val  = (duration_steps_r == '0) ? bec_pkg::U_ONE : quo_r[NDIV-1];
    u_dbl  = {u_val, 1'b0};
    lo_nxt = u_val < bec_pkg::U_HALF;
    case (ease_mode_r)
      bec_pkg::MODE_IN:    v_nxt = {1'b0, bec_pkg::U_ONE} - {1'b0, u_val};
      bec_pkg::MODE_INOUT: v_nxt = lo_nxt ? ({1'b0, bec_pkg::U_ONE} - u_dbl)
                                          : (u_dbl - {1'b0, bec_pkg::U_ONE});
      default:             v_nxt = {1'b0, u_val};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r  <= v_nxt[bec_pkg::U_W-1:0];
      lo_r <= lo_nxt;
    end
  end

  // pick the segment and the distance from its center
  logic [bec_pkg::M_W-1:0]   m11;
  logic signed [bec_pkg::M_W+1:0] ctr_off;
  logic [bec_pkg::M_W+1:0]   dist_abs;
  bec_pkg::seg_t             seg_nxt;
  bec_pkg::seg_t             seg_r;
  logic [bec_pkg::ABS_W-1:0] abs_r;
  logic                      seg_lo_r;

  always_comb begin
    m11 = bec_pkg::M_W'(v_r) * bec_pkg::M_W'(11);
    if (m11 < bec_pkg::M_BRK1) begin
      seg_nxt = bec_pkg::SEG_FIRST;
      ctr_off = signed'({2'b00, m11});
    end else if (m11 < bec_pkg::M_BRK2) begin
      seg_nxt = bec_pkg::SEG_SECOND;
      ctr_off = signed'({2'b00, m11}) - signed'({1'b0, bec_pkg::M_CTR1});
    end else if (m11 < bec_pkg::M_BRK3) begin
      seg_nxt = bec_pkg::SEG_THIRD;
      ctr_off = signed'({2'b00, m11}) - signed'({1'b0, bec_pkg::M_CTR2});
    end else begin
      seg_nxt = bec_pkg::SEG_LAST;
      ctr_off = signed'({1'b0, m11, 1'b0}) - signed'({1'b0, bec_pkg::M_CTR3});
    end
    dist_abs = ctr_off[bec_pkg::M_W+1] ? (~ctr_off + 1'b1) : ctr_off;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r    <= seg_nxt;
      abs_r    <= dist_abs[bec_pkg::ABS_W-1:0];
      seg_lo_r <= lo_r;
    end
  end

  // square
  logic [bec_pkg::SQ_W-1:0] sq_r;
  bec_pkg::seg_t            sq_seg_r;
  logic                     sq_lo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= abs_r * abs_r;
      sq_seg_r <= seg_r;
      sq_lo_r  <= seg_lo_r;
    end
  end

  // round into Q1.FRAC_BITS and add the segment offset
  logic [bec_pkg::SQ_W:0] sum0, sum3;
  logic [CW-1:0]          c_nxt;
  logic [CW-1:0]          c_r;
  logic                   c_lo_r;

  always_comb begin
    sum0 = {1'b0, sq_r} + RND0;
    sum3 = {1'b0, sq_r} + RND3;
    case (sq_seg_r)
      bec_pkg::SEG_FIRST:  c_nxt = CW'(sum0 >> SH0);
      bec_pkg::SEG_SECOND: c_nxt = CW'(sum0 >> SH0) + OFF1;
      bec_pkg::SEG_THIRD:  c_nxt = CW'(sum0 >> SH0) + OFF2;
      default:             c_nxt = CW'(sum3 >> SH3) + OFF3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_nxt;
      c_lo_r <= sq_lo_r;
    end
  end

  // combine by mode into Q1.(FRAC_BITS+1)
  logic [GW-1:0] g_nxt;
  logic [GW-1:0] g_r;

  always_comb begin
    case (ease_mode_r)
      bec_pkg::MODE_IN:    g_nxt = {C_ONE - c_r, 1'b0};
      bec_pkg::MODE_INOUT: g_nxt = c_lo_r ? GW'(C_ONE - c_r) : (GW'(c_r) + GW'(C_ONE));
      default:             g_nxt = {c_r, 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r <= g_nxt;
    end
  end

  // scale by the change amount
  logic signed [PW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PW'(change_amount_r * signed'({1'b0, g_r}));
    end
  end

  // round half up and add the start position
  logic signed [PW-1:0] p_rnd;
  logic signed [PW-1:0] p_int;
  logic signed [16:0]   fin_pos;

  assign p_rnd   = p_r + P_HALF;
  assign p_int   = p_rnd >>> (FRAC_BITS + 1);
  assign fin_pos = p_int[16:0] + {begin_value_r[15], begin_value_r};

  // output register with skid word behind it
  logic signed [16:0] out_pos_r;
  logic signed [16:0] skid_pos_r;
  logic               fin_take;

  assign fin_take = en && mul_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else if (!fin_take) begin
        out_valid_r <= 1'b0;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= fin_take;
    end else if (fin_take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_pos_r <= skid_pos_r;
      end else if (fin_take) begin
        out_pos_r <= fin_pos;
      end
    end else if (!out_valid_r) begin
      if (fin_take) begin
        out_pos_r <= fin_pos;
      end
    end else if (fin_take) begin
      skid_pos_r <= fin_pos;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  // a zero duration runs the divider against zero; its quotient is replaced later
  a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_vld_r[NDIV-1] && (duration_steps_r != '0)) |-> (quo_r[NDIV-1] <= bec_pkg::U_ONE))
    else $error("divider quotient above one");

  a_curve_range: assert property (@(posedge clk) disable iff (!rst_n)
    crv_vld_r |-> (c_r <= C_ONE))
    else $error("curve value above one");

  a_frozen_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && mul_vld_r) |=> $stable(p_r))
    else $error("pipe moved while skid word was held");

endmodule

// ===== tb/bounce_easing_curve_top_tb.sv =====
// bounce easing curve testbench: directed and random step counts against a local curve model
module bounce_easing_curve_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint U1 = 64'sd1 <<< bec_pkg::U_BITS;
  localparam int SQ_SHIFT = 2 * bec_pkg::U_BITS + 4 - FRAC;
  localparam int SQ_SHIFT_LAST = 2 * bec_pkg::U_BITS + 6 - FRAC;
  localparam bec_pkg::mode_t MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_elapsed_step = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [16:0] out_position;
  logic        cfg_we = 1'b0;
  bec_pkg::reg_idx_t cfg_index = bec_pkg::REG_MODE;
  logic [15:0] cfg_wdata = '0;

  // shadow copy of the register file
  bec_pkg::mode_t     mode_shadow = bec_pkg::MODE_OUT;
  logic signed [15:0] begin_shadow = '0;
  logic signed [15:0] change_shadow = '0;
  logic [15:0]        duration_shadow = bec_pkg::DURATION_RST;

  logic signed [16:0] pending_positions [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  bounce_easing_curve_top #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_elapsed_step(in_elapsed_step),
    .out_valid(out_valid), .out_ready(out_ready), .out_position(out_position),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // squared distance from a segment center, rounded into the curve format
  function automatic longint round_sq(input longint w, input int sh);
    longint m;
    m = (w < 0) ? -w : w;
    return (m * m + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint bounce_out_curve(input longint v);
    longint x;
    x = 11 * v;
    if (x < 4 * U1) return round_sq(x, SQ_SHIFT);
    if (x < 8 * U1) return round_sq(x - 6 * U1, SQ_SHIFT) + ((64'sd3 <<< FRAC) >>> 2);
    if (x < 10 * U1) return round_sq(x - 9 * U1, SQ_SHIFT) + ((64'sd15 <<< FRAC) >>> 4);
    return round_sq(2 * x - 21 * U1, SQ_SHIFT_LAST) + ((64'sd63 <<< FRAC) >>> 6);
  endfunction

  function automatic logic signed [16:0] eased_position(input logic [15:0] step);
    longint t, d, u, g, p, r;
    longint one;
    logic signed [16:0] pos;
    t = longint'(step);
    d = longint'(duration_shadow);
    one = 64'sd1 <<< FRAC;
    if (d == 0) begin
      u = U1;
    end else begin
      if (t > d) t = d;
      u = (t <<< bec_pkg::U_BITS) / d;
      if (u > U1) u = U1;
    end
    // g carries one extra fraction bit so the in-out halving is exact
    case (mode_shadow)
      bec_pkg::MODE_IN: g = (one - bounce_out_curve(U1 - u)) <<< 1;
      bec_pkg::MODE_INOUT: begin
        if (u < (U1 >>> 1)) g = one - bounce_out_curve(U1 - 2 * u);
        else g = bounce_out_curve(2 * u - U1) + one;
      end
      default: g = bounce_out_curve(u) <<< 1;
    endcase
    p = longint'(change_shadow) * g;
    r = (p + (64'sd1 <<< FRAC)) >>> (FRAC + 1);
    pos = 17'(longint'(begin_shadow) + r);
    return pos;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : position_check
    logic signed [16:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_positions.size() == 0) begin
        $display("%0t: unexpected position word, expected none, actual %0d",
                 $time, out_position);
        errors++;
      end else begin
        want = pending_positions.pop_front();
        if (out_position !== want) begin
          $display("%0t: position mismatch, expected %0d, actual %0d",
                   $time, want, out_position);
          errors++;
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_step(input logic [15:0] step);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_elapsed_step <= step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_positions.push_back(eased_position(step));
    @(negedge clk);
  endtask

  task automatic wait_positions_drained();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input bec_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_config(input bec_pkg::mode_t mode, input logic signed [15:0] bgn,
                            input logic signed [15:0] chg, input logic [15:0] dur);
    // upper bits of the mode word are junk that the block must drop
    cfg_write(bec_pkg::REG_MODE, {14'($urandom), mode});
    cfg_write(bec_pkg::REG_BEGIN, bgn);
    cfg_write(bec_pkg::REG_CHANGE, chg);
    cfg_write(bec_pkg::REG_DURATION, dur);
    cfg_we <= 1'b0;
    mode_shadow = mode;
    begin_shadow = bgn;
    change_shadow = chg;
    duration_shadow = dur;
  endtask

  task automatic test_reset_defaults();
    send_step(16'd0);
    send_step(16'd50);
    send_step(16'hFFFF);
  endtask

  task automatic test_segment_edges();
    wait_positions_drained();
    set_config(bec_pkg::MODE_OUT, -16'sd32768, 16'sd32767, 16'hFFFF);
    send_step(16'd0);
    send_step(16'd23830);
    send_step(16'd23831);
    send_step(16'd47662);
    send_step(16'd59578);
    send_step(16'hFFFF);
  endtask

  task automatic test_bounce_in();
    wait_positions_drained();
    set_config(bec_pkg::MODE_IN, 16'sd32767, -16'sd32768, 16'd1);
    send_step(16'd0);
    send_step(16'd1);
    send_step(16'hFFFF);
  endtask

  task automatic test_bounce_in_out();
    wait_positions_drained();
    set_config(bec_pkg::MODE_INOUT, 16'sd0, -16'sd32768, 16'd2);
    send_step(16'd0);
    send_step(16'd1);
    send_step(16'd2);
  endtask

  task automatic test_unused_mode();
    wait_positions_drained();
    set_config(MODE_UNUSED, 16'sd100, 16'sd32767, 16'd7);
    send_step(16'd3);
    send_step(16'd9);
  endtask

  task automatic test_zero_duration();
    wait_positions_drained();
    set_config(bec_pkg::MODE_IN, -16'sd32768, -16'sd32768, 16'd0);
    send_step(16'd0);
    send_step(16'hFFFF);
    wait_positions_drained();
    set_config(bec_pkg::MODE_INOUT, 16'sd1, 16'sd32767, 16'd0);
    send_step(16'd12345);
  endtask

  function automatic logic signed [15:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [15:0] dur;
    logic [15:0] step;
    int top;
    for (int ph = 0; ph < 20; ph++) begin
      wait_positions_drained();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      case ($urandom_range(0, 9))
        0: dur = 16'hFFFF;
        1: dur = 16'd1;
        2: dur = 16'd0;
        3, 4: dur = 16'($urandom_range(2, 20));
        5, 6: dur = 16'($urandom_range(21, 1000));
        default: dur = 16'($urandom);
      endcase
      set_config(bec_pkg::mode_t'($urandom_range(0, 3)), pick_amount(), pick_amount(), dur);
      top = (int'(dur) + 2 > 65535) ? 65535 : int'(dur) + 2;
      for (int k = 0; k < 50; k++) begin
        case ($urandom_range(0, 3))
          0, 1: step = 16'($urandom);
          2: step = 16'($urandom_range(0, top));
          default: step = dur;
        endcase
        send_step(step);
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    #2000000;
    $display("bounce_easing_curve_top_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_segment_edges();
    test_bounce_in();
    test_bounce_in_out();
    test_unused_mode();
    test_zero_duration();
    test_random_traffic();
    wait_positions_drained();
    // catch any stray word behind the last one
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("bounce_easing_curve_top_tb: done, clean");
    end else begin
      $display("bounce_easing_curve_top_tb: done, errors");
    end
    $finish;
  end

endmodule
